// ===== rtl/priority_task_scheduler_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Shorthand for clocked implications; the including scope supplies clk and
// rst_n.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pts_pkg.sv =====
// ---------------------------------------------------------------------------
// Task scheduler package
// Request, slot state and status codes, bus widths and shared types.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam int DEFAULT_NUM_SLOTS = 16;

  localparam int TASK_SLOT_W  = 4;
  localparam int PRIO_W       = 8;
  localparam int SLEEP_W      = 32;
  localparam int TICK_W       = 32;
  localparam int REQ_W        = 3;
  localparam int SLOT_STATE_W = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 48;

  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUSPEND = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELAY   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_START   = 3'd6;

  localparam logic [SLOT_STATE_W-1:0] ST_READY     = 2'd0;
  localparam logic [SLOT_STATE_W-1:0] ST_RUNNING   = 2'd1;
  localparam logic [SLOT_STATE_W-1:0] ST_BLOCKED   = 2'd2;
  localparam logic [SLOT_STATE_W-1:0] ST_SUSPENDED = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

  typedef struct packed {
    logic                    used;
    logic [SLOT_STATE_W-1:0] state;
    logic [PRIO_W-1:0]       prio;
    logic [SLEEP_W-1:0]      sleep;
  } slot_info_t;

  typedef struct packed {
    logic wake_hit;
    logic wake_ready;
    logic better;
  } alu_res_t;

endpackage

// ===== rtl/pts_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pts_slot_alu.sv =====
// ---------------------------------------------------------------------------
// Slot evaluation unit
// Shared per-slot arithmetic: delay countdown with wakeup detect, and the
// strict priority compare against the running best.
// ---------------------------------------------------------------------------
module pts_slot_alu import pts_pkg::*; (
  input  slot_info_t         info,
  input  logic [PRIO_W-1:0]  best,
  output alu_res_t           res,
  output logic [SLEEP_W-1:0] sleep_dec
);

  always_comb begin
    sleep_dec      = info.sleep - SLEEP_W'(1);
    res.wake_hit   = info.used && (info.state == ST_BLOCKED) && (info.sleep != '0);
    res.wake_ready = (info.sleep == SLEEP_W'(1));
    res.better     = info.used && (info.state == ST_READY) && (info.prio > best);
  end

endmodule

// ===== rtl/priority_task_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// Priority task scheduler
// Fixed-priority task table with create, delete, suspend, resume, delay,
// tick and start requests; one result transfer per request. Slot priority,
// state and delay live in three small RAMs; a sequencer walks the slots one
// per cycle through a shared evaluation unit. Delete, suspend, delay and
// unknown requests go from decode to the result; resume first reads the
// slot state. Create and start scan the used bits one slot a cycle, start
// then switching to the first used slot found. A tick walks the table twice
// through the RAM read port, once for wakeups and once for selection. A new
// request is taken while the previous result still waits on the output
// register.
// ---------------------------------------------------------------------------
`include "priority_task_scheduler_unit_macros.svh"

module priority_task_scheduler_unit import pts_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // task_slot, task_priority, delay_ticks
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [REQ_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, created_slot, running_valid, running_slot, switched, ticks_elapsed
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int EXT_W  = ((SLOT_W > TASK_SLOT_W) ? SLOT_W : TASK_SLOT_W) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_RESUME = 4'd3;
  localparam logic [3:0] S_WAKE   = 4'd4;
  localparam logic [3:0] S_PICK   = 4'd5;
  localparam logic [3:0] S_SEL    = 4'd6;
  localparam logic [3:0] S_MC0    = 4'd7;
  localparam logic [3:0] S_MC1    = 4'd8;
  localparam logic [3:0] S_MC2    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]             state_r, state_nxt;
  logic [REQ_W-1:0]       req_r;
  logic [TASK_SLOT_W-1:0] tslot_r;
  logic [PRIO_W-1:0]      tprio_r;
  logic [SLEEP_W-1:0]     tdelay_r;

  logic [NUM_SLOTS-1:0]   used_r, used_nxt;
  logic                   have_r, have_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [TICK_W-1:0]      tick_r, tick_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic                   issue_r, issue_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic [PRIO_W-1:0]      best_r, best_nxt;
  logic [SLOT_W-1:0]      pick_r, pick_nxt;
  logic                   found_r, found_nxt;
  logic                   sw_r, sw_nxt;
  logic [STATUS_W-1:0]    stat_r, stat_nxt;
  logic [SLOT_W-1:0]      created_r, created_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [EXT_W-1:0]        slot_ext;
  logic                    slot_in_range;
  logic [SLOT_W-1:0]       slot_idx;
  logic                    target_ok;
  logic                    in_xfer;

  logic [SLOT_W-1:0]       raddr;
  logic [SLOT_W-1:0]       waddr;
  logic                    prio_we, stat_we, sleep_we;
  logic [SLOT_STATE_W-1:0] stat_wd;
  logic [SLEEP_W-1:0]      sleep_wd;
  logic [PRIO_W-1:0]       prio_rd;
  logic [SLOT_STATE_W-1:0] stat_rd;
  logic [SLEEP_W-1:0]      sleep_rd;

  slot_info_t              ev_info;
  alu_res_t                alu_res;
  logic [SLEEP_W-1:0]      sleep_dec;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign slot_ext      = EXT_W'(tslot_r);
  assign slot_in_range = (slot_ext < EXT_W'(NUM_SLOTS));
  assign slot_idx      = slot_ext[SLOT_W-1:0];
  assign target_ok     = slot_in_range && used_r[slot_idx];

  assign ev_info.used  = used_r[ev_idx_r];
  assign ev_info.state = stat_rd;
  assign ev_info.prio  = prio_rd;
  assign ev_info.sleep = sleep_rd;

  pts_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (waddr),
    .wdata (tprio_r),
    .raddr (raddr),
    .rdata (prio_rd)
  );

  pts_ram #(.WIDTH(SLOT_STATE_W), .DEPTH(NUM_SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (waddr),
    .wdata (stat_wd),
    .raddr (raddr),
    .rdata (stat_rd)
  );

  pts_ram #(.WIDTH(SLEEP_W), .DEPTH(NUM_SLOTS)) u_sleep_ram (
    .clk   (clk),
    .we    (sleep_we),
    .waddr (waddr),
    .wdata (sleep_wd),
    .raddr (raddr),
    .rdata (sleep_rd)
  );

  pts_slot_alu u_alu (
    .info      (ev_info),
    .best      (best_r),
    .res       (alu_res),
    .sleep_dec (sleep_dec)
  );

  always_comb begin
    case (state_r)
      S_DECODE: raddr = slot_idx;
      S_MC0:    raddr = cur_r;
      default:  raddr = idx_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    have_nxt      = have_r;
    cur_nxt       = cur_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = idx_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    sw_nxt        = sw_r;
    stat_nxt      = stat_r;
    created_nxt   = created_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    waddr         = cur_r;
    prio_we       = 1'b0;
    stat_we       = 1'b0;
    sleep_we      = 1'b0;
    stat_wd       = ST_READY;
    sleep_wd      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt   = S_DECODE;
          stat_nxt    = STAT_OK;
          created_nxt = '0;
          sw_nxt      = 1'b0;
        end
      end

      S_DECODE: begin
        state_nxt = S_DONE;
        idx_nxt   = '0;
        case (req_r)
          REQ_CREATE, REQ_START: begin
            state_nxt = S_SCAN;
          end
          REQ_DELETE: begin
            if (!target_ok) begin
              stat_nxt = STAT_NOT_USED;
            end else begin
              used_nxt[slot_idx] = 1'b0;
              if (have_r && cur_r == slot_idx) begin
                have_nxt = 1'b0;
                cur_nxt  = '0;
              end
            end
          end
          REQ_SUSPEND: begin
            if (!target_ok) begin
              stat_nxt = STAT_NOT_USED;
            end else begin
              waddr   = slot_idx;
              stat_we = 1'b1;
              stat_wd = ST_SUSPENDED;
            end
          end
          REQ_RESUME: begin
            if (!target_ok) begin
              stat_nxt = STAT_NOT_USED;
            end else begin
              state_nxt = S_RESUME;
            end
          end
          REQ_DELAY: begin
            if (have_r && used_r[cur_r]) begin
              waddr    = cur_r;
              sleep_we = 1'b1;
              sleep_wd = tdelay_r;
              stat_we  = 1'b1;
              stat_wd  = ST_BLOCKED;
            end
          end
          REQ_TICK: begin
            tick_nxt  = tick_r + TICK_W'(1);
            issue_nxt = 1'b1;
            state_nxt = S_WAKE;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        idx_nxt = idx_r + SLOT_W'(1);
        if (req_r == REQ_CREATE) begin
          if (!used_r[idx_r]) begin
            used_nxt[idx_r] = 1'b1;
            waddr       = idx_r;
            prio_we     = 1'b1;
            stat_we     = 1'b1;
            stat_wd     = ST_READY;
            sleep_we    = 1'b1;
            sleep_wd    = '0;
            created_nxt = idx_r;
            state_nxt   = S_DONE;
          end else if (idx_r == LAST_SLOT) begin
            stat_nxt  = STAT_FULL;
            state_nxt = S_DONE;
          end
        end else begin
          if (used_r[idx_r]) begin
            pick_nxt  = idx_r;
            state_nxt = S_MC0;
          end else if (idx_r == LAST_SLOT) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_RESUME: begin
        if (stat_rd == ST_SUSPENDED) begin
          waddr   = slot_idx;
          stat_we = 1'b1;
          stat_wd = ST_READY;
        end
        state_nxt = S_DONE;
      end

      S_WAKE, S_PICK: begin
        ev_vld_nxt = issue_r;
        ev_idx_nxt = idx_r;
        if (issue_r) begin
          if (idx_r == LAST_SLOT) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
        if (ev_vld_r) begin
          waddr = ev_idx_r;
          if (state_r == S_WAKE) begin
            if (alu_res.wake_hit) begin
              sleep_we = 1'b1;
              sleep_wd = sleep_dec;
              if (alu_res.wake_ready) begin
                stat_we = 1'b1;
                stat_wd = ST_READY;
              end
            end
          end else if (alu_res.better) begin
            best_nxt  = prio_rd;
            pick_nxt  = ev_idx_r;
            found_nxt = 1'b1;
          end
        end
        if (ev_vld_r && !issue_r) begin
          ev_vld_nxt = 1'b0;
          if (state_r == S_WAKE) begin
            state_nxt = S_PICK;
            idx_nxt   = '0;
            issue_nxt = 1'b1;
            best_nxt  = '0;
            found_nxt = 1'b0;
          end else begin
            state_nxt = S_SEL;
          end
        end
      end

      S_SEL: begin
        if (found_r && !(have_r && cur_r == pick_r)) begin
          sw_nxt    = 1'b1;
          state_nxt = S_MC0;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_MC0: begin
        state_nxt = S_MC1;
      end

      S_MC1: begin
        if (have_r && cur_r != pick_r && used_r[cur_r] && stat_rd == ST_RUNNING) begin
          waddr   = cur_r;
          stat_we = 1'b1;
          stat_wd = ST_READY;
        end
        state_nxt = S_MC2;
      end

      S_MC2: begin
        waddr     = pick_r;
        stat_we   = 1'b1;
        stat_wd   = ST_RUNNING;
        have_nxt  = 1'b1;
        cur_nxt   = pick_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, tick_r, sw_r,
                           (have_r ? TASK_SLOT_W'(cur_r) : TASK_SLOT_W'(0)),
                           have_r, TASK_SLOT_W'(created_r), stat_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      have_r      <= 1'b0;
      cur_r       <= '0;
      tick_r      <= '0;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      ev_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      have_r      <= have_nxt;
      cur_r       <= cur_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      ev_vld_r    <= ev_vld_nxt;
      found_r     <= found_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r    <= in_tuser;
      tslot_r  <= in_tdata[TASK_SLOT_W-1:0];
      tprio_r  <= in_tdata[TASK_SLOT_W +: PRIO_W];
      tdelay_r <= in_tdata[TASK_SLOT_W+PRIO_W +: SLEEP_W];
    end
    ev_idx_r   <= ev_idx_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    stat_r     <= stat_nxt;
    created_r  <= created_nxt;
    out_data_r <= out_data_nxt;
  end

  `PTS_ASSERT_NXT(a_accept_decode, in_xfer, state_r == S_DECODE, "accept did not start decode")
  `PTS_ASSERT_IMP(a_cur_used, have_r, used_r[cur_r], "current task slot not in use")
  `PTS_ASSERT_IMP(a_issue_pass, issue_r, state_r == S_WAKE || state_r == S_PICK, "read issue outside pass")
  `PTS_ASSERT_NXT(a_done_load, state_r == S_DONE && (!out_valid_r || out_tready), out_valid_r && state_r == S_IDLE, "result not loaded")

endmodule
